>>> hdl/ipyu_pkg.sv
package ipyu_pkg;

  localparam int unsigned FRAME_LEN      = 11;
  localparam int unsigned CELL_COUNT     = FRAME_LEN - 1;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned REV_COUNT_BITS = 16;

  localparam logic [7:0]  FRAME_HEAD = 8'h55;
  localparam logic [7:0]  TYPE_ACC   = 8'h51;
  localparam logic [7:0]  TYPE_RATE  = 8'h52;
  localparam logic [7:0]  TYPE_ANGLE = 8'h53;

  localparam logic [15:0] THR_RESET  = 16'd54614;

  typedef enum logic [1:0] {
    KIND_ACC   = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } frame_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

>>> hdl/ipyu_byte_if.sv
interface ipyu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       buffer_end;

  modport source (output valid, byte_in, buffer_end, input ready);
  modport sink   (input valid, byte_in, buffer_end, output ready);
endinterface

>>> hdl/ipyu_res_if.sv
interface ipyu_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         packet_kind;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic signed [15:0] z_value;
  logic signed [32:0] yaw_unwrapped;
  logic signed [32:0] yaw_from_zero;

  modport source (output valid, packet_kind, x_value, y_value, z_value, yaw_unwrapped,
                  yaw_from_zero, input ready);
  modport sink   (input valid, packet_kind, x_value, y_value, z_value, yaw_unwrapped,
                  yaw_from_zero, output ready);
endinterface

>>> hdl/ipyu_cfg_if.sv
interface ipyu_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/ipyu_cell.sv
module ipyu_cell
  import ipyu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] d_i,
  output logic [7:0] q_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= d_i;
    end
  end

  assign q_o = byte_q;

endmodule

>>> hdl/ipyu_unwrap.sv
module ipyu_unwrap
  import ipyu_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    thr_i,
  input  hs_t            s1_hs_i,
  input  frame_t         s1_i,
  output logic           s1_take_o,
  ipyu_res_if.source     res_o
);

  localparam int unsigned R     = REV_COUNT_BITS;
  localparam int unsigned UNW_W = (R + 17 > 34) ? R + 17 : 34;

  localparam logic signed [R-1:0]  REV_MAX = {1'b0, {(R-1){1'b1}}};
  localparam logic signed [R-1:0]  REV_MIN = {1'b1, {(R-1){1'b0}}};
  localparam logic signed [32:0]   YAW_HI  = {1'b0, {32{1'b1}}};
  localparam logic signed [32:0]   YAW_LO  = {1'b1, {32{1'b0}}};

  logic               captured_q;
  logic signed [15:0] prev_q;
  logic signed [15:0] off_q;
  logic signed [R-1:0] revs_q;
  logic signed [32:0] last_unw_q;

  logic               s2_v_q;
  frame_t             s2_q;
  logic signed [15:0] s2_off_q;

  logic               s3_v_q;
  frame_t             s3_q;
  logic signed [32:0] s3_unw_q;
  logic signed [15:0] s3_off_q;

  logic               out_v_q;

  logic out_move, s3_move, s2_move;
  logic is_angle;

  logic signed [16:0] diff;
  logic signed [16:0] thr_pos;
  logic signed [16:0] thr_neg;
  logic               wrap_dn;
  logic               wrap_up;
  logic signed [R-1:0] revs_d;
  logic signed [15:0] off_d;

  logic signed [UNW_W-1:0] unw_full;
  logic signed [32:0]      unw_sat;
  logic signed [32:0]      unw_d;
  logic signed [33:0]      fz_full;
  logic signed [32:0]      fz_sat;

  assign out_move  = s3_v_q && (!out_v_q || res_o.ready);
  assign s3_move   = s2_v_q && (!s3_v_q || out_move);
  assign s2_move   = s1_hs_i.valid && (!s2_v_q || s3_move);
  assign s1_take_o = s2_move;

  assign is_angle = (s1_i.kind == KIND_ANGLE);

  assign diff    = {s1_i.z[15], s1_i.z} - {prev_q[15], prev_q};
  assign thr_pos = $signed({1'b0, thr_i});
  assign thr_neg = -thr_pos;
  assign wrap_dn = (diff >= thr_pos);
  assign wrap_up = !wrap_dn && (diff <= thr_neg);

  always_comb begin
    revs_d = revs_q;
    off_d  = off_q;
    if (is_angle) begin
      if (!captured_q) begin
        off_d = s1_i.z;
      end else if (wrap_dn) begin
        if (revs_q > REV_MIN) revs_d = revs_q - 1'b1;
      end else if (wrap_up) begin
        if (revs_q < REV_MAX) revs_d = revs_q + 1'b1;
      end
    end
  end

  assign unw_full = $signed({{(UNW_W-R-16){revs_q[R-1]}}, revs_q, 16'h0000})
                  + $signed({{(UNW_W-16){s2_q.z[15]}}, s2_q.z});

  always_comb begin
    if (unw_full[UNW_W-1:32] == {(UNW_W-32){unw_full[32]}}) begin
      unw_sat = unw_full[32:0];
    end else if (unw_full[UNW_W-1]) begin
      unw_sat = YAW_LO;
    end else begin
      unw_sat = YAW_HI;
    end
  end

  assign unw_d = (s2_q.kind == KIND_ANGLE) ? unw_sat : last_unw_q;

  assign fz_full = {s3_unw_q[32], s3_unw_q} - {{18{s3_off_q[15]}}, s3_off_q};

  always_comb begin
    if (fz_full[33] == fz_full[32]) begin
      fz_sat = fz_full[32:0];
    end else if (fz_full[33]) begin
      fz_sat = YAW_LO;
    end else begin
      fz_sat = YAW_HI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      captured_q <= 1'b0;
      prev_q     <= '0;
      off_q      <= '0;
      revs_q     <= '0;
      last_unw_q <= '0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (s2_move && is_angle) begin
        captured_q <= 1'b1;
        prev_q     <= s1_i.z;
        off_q      <= off_d;
        revs_q     <= revs_d;
      end
      if (s3_move) begin
        last_unw_q <= unw_d;
      end
      if (s2_move) begin
        s2_v_q <= 1'b1;
      end else if (s3_move) begin
        s2_v_q <= 1'b0;
      end
      if (s3_move) begin
        s3_v_q <= 1'b1;
      end else if (out_move) begin
        s3_v_q <= 1'b0;
      end
      if (out_move) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      s2_q     <= s1_i;
      s2_off_q <= off_d;
    end
    if (s3_move) begin
      s3_q     <= s2_q;
      s3_unw_q <= unw_d;
      s3_off_q <= s2_off_q;
    end
    if (out_move) begin
      res_o.packet_kind   <= s3_q.kind;
      res_o.x_value       <= s3_q.x;
      res_o.y_value       <= s3_q.y;
      res_o.z_value       <= s3_q.z;
      res_o.yaw_unwrapped <= s3_unw_q;
      res_o.yaw_from_zero <= fz_sat;
    end
  end

  assign res_o.valid = out_v_q;

endmodule

>>> hdl/imu_packet_parser_yaw_unwrap_unit.sv
// Channel  | Dir | Payload                                         | Transaction
// in_i     | in  | byte_in[7:0], buffer_end                        | valid & ready
// res_o    | out | packet_kind, x/y/z_value, yaw_unwrapped/_from_zero | valid & ready
// cfg_i    | in  | data[15:0] = unwrap_threshold                   | valid & ready
//
// One byte per cycle while in_i.ready is high. A result passes the parse, unwrap,
// yaw and output register stages after the byte that closes its frame.
// Async active-low reset clears byte cells, counter and yaw state, presets threshold.
// in_i.ready drops only while a parsed frame waits behind a stalled result.
module imu_packet_parser_yaw_unwrap_unit
  import ipyu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ipyu_byte_if.sink   in_i,
  ipyu_res_if.source  res_o,
  ipyu_cfg_if.sink    cfg_i
);

  logic [7:0]       cells [CELL_COUNT];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      thr_q;
  logic             s1_v_q;
  frame_t           s1_q;
  frame_t           s1_d;
  hs_t              s1_hs;
  logic             s1_take;

  logic             in_acc;
  logic [7:0]       cksum;
  logic             frame_hit;
  logic             known;

  assign in_acc = in_i.valid && in_i.ready;

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    logic [7:0] d;
    if (k == CELL_COUNT - 1) begin : g_last
      assign d = in_i.byte_in;
    end else begin : g_mid
      assign d = cells[k+1];
    end
    ipyu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(in_acc),
      .d_i    (d),
      .q_o    (cells[k])
    );
  end

  assign cksum = ((cells[0] + cells[1]) + (cells[2] + cells[3]))
               + ((cells[4] + cells[5]) + (cells[6] + cells[7]))
               + (cells[8] + cells[9]);

  assign frame_hit = (cnt_q >= CNT_W'(FRAME_LEN - 1)) && (cells[0] == FRAME_HEAD)
                  && (cksum == in_i.byte_in);

  always_comb begin
    known     = 1'b1;
    s1_d.kind = KIND_ACC;
    unique case (cells[1])
      TYPE_ACC:   s1_d.kind = KIND_ACC;
      TYPE_RATE:  s1_d.kind = KIND_RATE;
      TYPE_ANGLE: s1_d.kind = KIND_ANGLE;
      default:    known = 1'b0;
    endcase
    s1_d.x = {cells[3], cells[2]};
    s1_d.y = {cells[5], cells[4]};
    s1_d.z = {cells[7], cells[6]};
  end

  always_comb begin
    if (frame_hit || in_i.buffer_end) begin
      cnt_d = '0;
    end else if (cnt_q >= CNT_W'(FRAME_LEN)) begin
      cnt_d = CNT_W'(FRAME_LEN);
    end else begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      thr_q  <= THR_RESET;
      s1_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q <= cnt_d;
      end
      if (cfg_i.valid) begin
        thr_q <= cfg_i.data;
      end
      if (in_acc && frame_hit && known) begin
        s1_v_q <= 1'b1;
      end else if (s1_take) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && frame_hit && known) begin
      s1_q <= s1_d;
    end
  end

  assign s1_hs.valid = s1_v_q;
  assign s1_hs.ready = s1_take;
  assign in_i.ready  = !s1_v_q || s1_take;
  assign cfg_i.ready = 1'b1;

  ipyu_unwrap u_unwrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .thr_i    (thr_q),
    .s1_hs_i  (s1_hs),
    .s1_i     (s1_q),
    .s1_take_o(s1_take),
    .res_o    (res_o)
  );

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FRAME_LEN))
    else $error("byte counter beyond frame length");

  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_hit) |=> (cnt_q == '0))
    else $error("counter not cleared after frame");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_v_q && !s1_take))
    else $error("input stalled with empty parse stage");

  a_frame_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_hit) |-> (cnt_q >= CNT_W'(FRAME_LEN - 1)))
    else $error("frame accepted too early");

endmodule
